// File: rtl/core/trapezoid_velocity_profile_eval_macros.svh
// ----------------------------------------------------------------------------
// trapezoid velocity profile evaluator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_VELOCITY_PROFILE_EVAL_MACROS_SVH
`define TRAPEZOID_VELOCITY_PROFILE_EVAL_MACROS_SVH

// same-cycle implication
`define TVP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvp assertion failed");

// next-cycle implication
`define TVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvp assertion failed");

`endif

// File: rtl/core/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// types and constants of the trapezoid velocity profile evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tvp_pkg;

  // field width of ports and configuration registers
  localparam int DATA_W = 32;
  // quotient bits of the per-item velocity divide (velocity never exceeds |vc|)
  localparam int QBITS = 32;
  // dividend bits of the configuration divider
  localparam int SDIV_W = 64;

  // configuration register indexes
  localparam logic [2:0] REG_INIT_POS   = 3'd0;
  localparam logic [2:0] REG_FINAL_POS  = 3'd1;
  localparam logic [2:0] REG_CRUISE_SPD = 3'd2;
  localparam logic [2:0] REG_DURATION   = 3'd3;
  localparam logic [2:0] REG_START_TIME = 3'd4;

  // phase codes
  localparam logic [2:0] PH_BEFORE = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_AFTER  = 3'd4;

  // derived-value sequencer
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_CHECK,
    SEQ_DIV_TC,
    SEQ_LOAD_ACC,
    SEQ_DIV_ACC
  } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/core/trapezoid_velocity_profile_eval.sv
// pipeline: 36 register stages (2 front stages, 32 one-bit divider stages for velocity,
//   a product stage and the output register) lie between a taken start and done
// throughput: one sample per cycle while busy is low; the receiver cannot stall
// after reset and after every configuration write, busy stays high
//   while a bit-serial divider derives blend time and acceleration (3 + 2 x 64 steps)
// reset is synchronous active high, loads register defaults and clears all valids
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile_eval
// pipelined evaluator of a trapezoidal velocity profile at a sample time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module trapezoid_velocity_profile_eval
  import tvp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [DATA_W-1:0]        sample_time,
  output logic                          done,
  output logic signed [DATA_W-1:0]      position,
  output logic signed [DATA_W-1:0]      velocity,
  output logic signed [DATA_W-1:0]      acceleration,
  output logic [2:0]                    phase,
  output logic                          profile_ok,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  `include "trapezoid_velocity_profile_eval_macros.svh"

  localparam int WW  = 66;
  localparam int LAT = QBITS + 4;
  localparam logic signed [WW-1:0] SAT_HI = (66'sd1 <<< (VALUE_WIDTH - 1)) - 66'sd1;
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - 66'sd1;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[DATA_W-1:0];
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0] start_pos, end_pos, cruise_vel;
  logic [DATA_W-1:0]        motion_duration, start_time;
  logic                     cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos       <= '0;
      end_pos         <= '0;
      cruise_vel      <= '0;
      motion_duration <= 32'd65536;
      start_time      <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_INIT_POS:   start_pos       <= cfg_data;
        REG_FINAL_POS:  end_pos         <= cfg_data;
        REG_CRUISE_SPD: cruise_vel      <= cfg_data;
        REG_DURATION:   motion_duration <= cfg_data;
        REG_START_TIME: start_time      <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitudes of distance and speed
  logic signed [DATA_W:0] delta;
  logic [DATA_W-1:0]      dist_mag, spd_mag;
  logic                   spd_neg;
  logic [SDIV_W:0]        lhs;

  assign delta    = {end_pos[DATA_W-1], end_pos}
                  - {start_pos[DATA_W-1], start_pos};
  assign dist_mag = delta[DATA_W] ? DATA_W'(-delta) : delta[DATA_W-1:0];
  assign spd_neg  = cruise_vel[DATA_W-1];
  assign spd_mag  = spd_neg ? DATA_W'(-cruise_vel) : cruise_vel;
  assign lhs      = (SDIV_W+1)'({33'd0, dist_mag}) << FRAC_BITS;

  // derived values and their sequencer
  seq_state_t              state, state_next;
  logic [2*DATA_W-1:0]     vt;
  logic                    cfg_ok, cfg_ok_next;
  logic [DATA_W-1:0]       blend_time, blend_time_next;
  logic [SDIV_W-1:0]       accel_mag, accel_mag_next;
  logic [SDIV_W-1:0]       snum, snum_next, squo, squo_next;
  logic [DATA_W-1:0]       srem, srem_next, sden, sden_next;
  logic [5:0]              scnt, scnt_next;
  logic [DATA_W:0]         s_sh, s_diff;
  logic                    s_ge, opp_sign;
  logic [SDIV_W-1:0]       s_qstep;

  assign s_sh    = {srem, snum[SDIV_W-1]};
  assign s_diff  = s_sh - {1'b0, sden};
  assign s_ge    = s_sh >= {1'b0, sden};
  assign s_qstep = {squo[SDIV_W-2:0], s_ge};
  assign opp_sign = (delta[DATA_W] && !spd_neg && cruise_vel != '0)
                 || (!delta[DATA_W] && delta != '0 && spd_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_MUL;
    end else if (cfg_xfer) begin
      state <= SEQ_MUL;
    end else begin
      state <= state_next;
    end
    vt         <= spd_mag * motion_duration;
    cfg_ok     <= cfg_ok_next;
    blend_time <= blend_time_next;
    accel_mag  <= accel_mag_next;
    snum       <= snum_next;
    squo       <= squo_next;
    srem       <= srem_next;
    sden       <= sden_next;
    scnt       <= scnt_next;
  end

  // sequencer: wait for the product, feasibility check, then two bit-serial divides
  always_comb begin
    state_next      = state;
    cfg_ok_next     = cfg_ok;
    blend_time_next = blend_time;
    accel_mag_next  = accel_mag;
    snum_next       = {snum[SDIV_W-2:0], 1'b0};
    squo_next       = s_qstep;
    srem_next       = s_ge ? s_diff[DATA_W-1:0] : s_sh[DATA_W-1:0];
    sden_next       = sden;
    scnt_next       = scnt + 6'd1;
    case (state)
      SEQ_IDLE: begin
        snum_next = snum;
        squo_next = squo;
        srem_next = srem;
        scnt_next = scnt;
      end
      SEQ_MUL: begin
        state_next = SEQ_CHECK;
      end
      SEQ_CHECK: begin
        cfg_ok_next = motion_duration != '0 && lhs < {1'b0, vt}
                   && {1'b0, vt} <= (lhs << 1) && !opp_sign;
        snum_next   = lhs[SDIV_W-1:0];
        squo_next   = '0;
        srem_next   = '0;
        sden_next   = spd_mag;
        scnt_next   = '0;
        state_next  = SEQ_DIV_TC;
      end
      SEQ_DIV_TC: begin
        if (scnt == 6'd63) begin
          blend_time_next = motion_duration - s_qstep[DATA_W-1:0];
          state_next      = SEQ_LOAD_ACC;
        end
      end
      SEQ_LOAD_ACC: begin
        snum_next  = SDIV_W'({32'd0, spd_mag}) << FRAC_BITS;
        squo_next  = '0;
        srem_next  = '0;
        sden_next  = blend_time;
        scnt_next  = '0;
        state_next = SEQ_DIV_ACC;
      end
      SEQ_DIV_ACC: begin
        if (scnt == 6'd63) begin
          accel_mag_next = s_qstep;
          state_next     = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_MUL;
    endcase
  end

  assign busy = (state != SEQ_IDLE);

  // stage 1: time offset, phase, divide operand and cruise argument
  logic [DATA_W:0]   t_diff, c_arg;
  logic [DATA_W-1:0] ut, u_sel, cruise_end;
  logic [2:0]        ph_sel;
  logic              s1_valid;
  logic [2:0]        s1_phase;
  logic [DATA_W-1:0] s1_u;
  logic [DATA_W:0]   s1_c;

  assign t_diff     = {1'b0, sample_time} - {1'b0, start_time};
  assign ut         = t_diff[DATA_W-1:0];
  assign cruise_end = motion_duration - blend_time;
  assign c_arg      = {ut, 1'b0} - {1'b0, blend_time};

  always_comb begin
    if (t_diff[DATA_W])                ph_sel = PH_BEFORE;
    else if (ut <= blend_time)         ph_sel = PH_ACCEL;
    else if (ut <= cruise_end)         ph_sel = PH_CRUISE;
    else if (ut <= motion_duration)    ph_sel = PH_DECEL;
    else                               ph_sel = PH_AFTER;
    u_sel = (ph_sel == PH_ACCEL) ? ut : motion_duration - ut;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
    s1_phase <= ph_sel;
    s1_u     <= u_sel;
    s1_c     <= c_arg;
  end

  // stage 2: products feeding the divider and the cruise position
  logic              dv_valid [0:QBITS];
  logic [2:0]        dv_phase [0:QBITS];
  logic [DATA_W-1:0] dv_u     [0:QBITS];
  logic [2*DATA_W:0] dv_cp    [0:QBITS];
  logic [DATA_W-1:0] dv_rem   [0:QBITS];
  logic [DATA_W-1:0] dv_lo    [0:QBITS];
  logic [QBITS-1:0]  dv_quo   [0:QBITS];
  logic [2*DATA_W-1:0] num_prod;

  assign num_prod = spd_mag * s1_u;

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else     dv_valid[0] <= s1_valid;
    dv_phase[0] <= s1_phase;
    dv_u[0]     <= s1_u;
    dv_cp[0]    <= (2*DATA_W+1)'(spd_mag * s1_c);
    dv_rem[0]   <= num_prod[2*DATA_W-1:DATA_W];
    dv_lo[0]    <= num_prod[DATA_W-1:0];
    dv_quo[0]   <= '0;
  end

  // one quotient bit per stage of v = |vc| * u / tc
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    logic [DATA_W:0] sh, diff;
    logic            ge;
    assign sh   = {dv_rem[j], dv_lo[j][DATA_W-1]};
    assign diff = sh - {1'b0, blend_time};
    assign ge   = sh >= {1'b0, blend_time};
    always_ff @(posedge clk) begin
      if (rst) dv_valid[j+1] <= 1'b0;
      else     dv_valid[j+1] <= dv_valid[j];
      dv_phase[j+1] <= dv_phase[j];
      dv_u[j+1]     <= dv_u[j];
      dv_cp[j+1]    <= dv_cp[j];
      dv_rem[j+1]   <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
      dv_lo[j+1]    <= {dv_lo[j][DATA_W-2:0], 1'b0};
      dv_quo[j+1]   <= {dv_quo[j][QBITS-2:0], ge};
    end
  end

  // stage 3: position magnitude
  logic [2*DATA_W-1:0] blend_prod;
  logic                s3_valid;
  logic [2:0]          s3_phase;
  logic [QBITS-1:0]    s3_v;
  logic [2*DATA_W:0]   s3_p;

  assign blend_prod = dv_quo[QBITS] * dv_u[QBITS];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= dv_valid[QBITS];
    s3_phase <= dv_phase[QBITS];
    s3_v     <= dv_quo[QBITS];
    s3_p     <= (dv_phase[QBITS] == PH_CRUISE) ? (dv_cp[QBITS] >> (FRAC_BITS + 1))
              : (2*DATA_W+1)'(blend_prod >> (FRAC_BITS + 1));
  end

  // output stage: sign, offset and saturate
  logic signed [WW-1:0] pi_w, pf_w, vc_w, p_s, v_s, a_s;
  logic signed [WW-1:0] pos_w, vel_w, acc_w;
  logic [2:0]           ph_out;

  assign pi_w = WW'(start_pos);
  assign pf_w = WW'(end_pos);
  assign vc_w = WW'(cruise_vel);
  assign p_s  = spd_neg ? -$signed({1'b0, s3_p}) : $signed({1'b0, s3_p});
  assign v_s  = spd_neg ? -$signed(WW'({1'b0, s3_v})) : $signed(WW'({1'b0, s3_v}));
  assign a_s  = spd_neg ? -$signed(WW'({1'b0, accel_mag})) : $signed(WW'({1'b0, accel_mag}));

  always_comb begin
    pos_w  = pi_w;
    vel_w  = '0;
    acc_w  = '0;
    ph_out = cfg_ok ? s3_phase : PH_BEFORE;
    if (cfg_ok) begin
      case (s3_phase)
        PH_ACCEL: begin
          pos_w = pi_w + p_s;
          vel_w = v_s;
          acc_w = a_s;
        end
        PH_CRUISE: begin
          pos_w = pi_w + p_s;
          vel_w = vc_w;
        end
        PH_DECEL: begin
          pos_w = pf_w - p_s;
          vel_w = v_s;
          acc_w = -a_s;
        end
        PH_AFTER: pos_w = pf_w;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s3_valid;
    position     <= sat(pos_w);
    velocity     <= sat(vel_w);
    acceleration <= sat(acc_w);
    phase        <= ph_out;
    profile_ok   <= cfg_ok;
  end

  // checks
  `TVP_ASSERT_NEXT(a_cfg_recompute, cfg_xfer, busy)
  `TVP_ASSERT_IMPL(a_latency, start && !busy && !cfg_xfer, ##LAT done)
  `TVP_ASSERT_IMPL(a_infeasible_rest, done && !profile_ok,
                   phase == PH_BEFORE && velocity == '0 && acceleration == '0)
  `TVP_ASSERT_IMPL(a_cruise_no_accel, done && phase == PH_CRUISE, acceleration == '0)

endmodule
`default_nettype wire

// File: dv/trapezoid_velocity_profile_eval_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid velocity profile evaluator testbench
// checks position, velocity, acceleration, phase and feasibility at sample
// times across directed and random profiles against a built-in predictor
// ----------------------------------------------------------------------------

// expected profile values and their checking
class profile_scoreboard;
  typedef struct {
    bit [31:0] position;
    bit [31:0] velocity;
    bit [31:0] acceleration;
    bit [2:0]  phase;
    bit        ok;
  } sample_result_t;

  localparam int FRAC = 16;

  bit [31:0] init_pos;
  bit [31:0] final_pos;
  bit [31:0] cruise;
  bit [31:0] duration;
  bit [31:0] t_start;
  sample_result_t pending[$];
  int errors;
  int matched;
  int feasible_seen;
  int phase_hits[5];

  function new();
    init_pos  = '0;
    final_pos = '0;
    cruise    = '0;
    duration  = 32'd65536;
    t_start   = '0;
  endfunction

  // register write as the block sees it
  function void write_reg(bit [2:0] idx, bit [31:0] val);
    case (idx)
      tvp_pkg::REG_INIT_POS:   init_pos = val;
      tvp_pkg::REG_FINAL_POS:  final_pos = val;
      tvp_pkg::REG_CRUISE_SPD: cruise = val;
      tvp_pkg::REG_DURATION:   duration = val;
      tvp_pkg::REG_START_TIME: t_start = val;
      default: ;
    endcase
  endfunction

  function longint apply_sign(bit [63:0] m, bit neg);
    longint s;
    s = longint'({1'b0, m[62:0]});
    return neg ? -s : s;
  endfunction

  function bit [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // profile evaluation for one accepted sample time
  function void note_sample(bit [31:0] ts);
    longint pi, pf, vc, d, t, pos, vel, acc;
    bit [63:0] ad, avc, lhs, vt, dur, tc, am, ut, v, p, s;
    bit neg, ok;
    bit [2:0] ph;
    sample_result_t r;
    pi  = longint'($signed(init_pos));
    pf  = longint'($signed(final_pos));
    vc  = longint'($signed(cruise));
    dur = {32'b0, duration};
    t   = longint'({32'b0, ts}) - longint'({32'b0, t_start});
    d   = pf - pi;
    ad  = d < 0 ? -d : d;
    avc = vc < 0 ? -vc : vc;
    lhs = ad << FRAC;
    vt  = avc * dur;
    neg = vc < 0;
    ok  = dur != 0 && lhs < vt && vt <= (ad << (FRAC + 1)) &&
          !((d < 0 && vc > 0) || (d > 0 && vc < 0));
    pos = pi; vel = 0; acc = 0; ph = tvp_pkg::PH_BEFORE;
    if (ok) begin
      tc = dur - lhs / avc;
      am = (avc << FRAC) / tc;
      if (t >= 0) begin
        ut = t;
        if (ut <= tc) begin
          v = avc * ut / tc;
          p = (v * ut) >> (FRAC + 1);
          pos = pi + apply_sign(p, neg);
          vel = apply_sign(v, neg);
          acc = apply_sign(am, neg);
          ph = tvp_pkg::PH_ACCEL;
        end else if (ut <= dur - tc) begin
          p = (avc * (64'd2 * ut - tc)) >> (FRAC + 1);
          pos = pi + apply_sign(p, neg);
          vel = vc;
          ph = tvp_pkg::PH_CRUISE;
        end else if (ut <= dur) begin
          s = dur - ut;
          v = avc * s / tc;
          p = (v * s) >> (FRAC + 1);
          pos = pf - apply_sign(p, neg);
          vel = apply_sign(v, neg);
          acc = -apply_sign(am, neg);
          ph = tvp_pkg::PH_DECEL;
        end else begin
          pos = pf;
          ph = tvp_pkg::PH_AFTER;
        end
      end
      feasible_seen++;
    end
    phase_hits[ph]++;
    r.position = clamp32(pos);
    r.velocity = clamp32(vel);
    r.acceleration = clamp32(acc);
    r.phase = ph;
    r.ok = ok;
    pending.push_back(r);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // compare one strobed result with the oldest expectation
  task check_result(bit [31:0] pos, bit [31:0] vel, bit [31:0] acc, bit [2:0] ph,
                    bit ok);
    sample_result_t e;
    if (pending.size() == 0) begin
      report("result with no sample outstanding");
    end else begin
      e = pending.pop_front();
      if (pos !== e.position)
        report($sformatf("position %h, expected %h", pos, e.position));
      if (vel !== e.velocity)
        report($sformatf("velocity %h, expected %h", vel, e.velocity));
      if (acc !== e.acceleration)
        report($sformatf("acceleration %h, expected %h", acc, e.acceleration));
      if (ph !== e.phase)
        report($sformatf("phase %0d, expected %0d", ph, e.phase));
      if (ok !== e.ok)
        report($sformatf("profile_ok %0d, expected %0d", ok, e.ok));
      matched++;
    end
  endtask
endclass

module trapezoid_velocity_profile_eval_test;
  import tvp_pkg::*;

  localparam int  RANDOM_SAMPLES = 1300;
  localparam int  CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [DATA_W-1:0] sample_time;
  logic done;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] acceleration;
  logic [2:0] phase;
  logic profile_ok;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  profile_scoreboard sb;
  int cycles;
  int sent;
  int profiles;

  trapezoid_velocity_profile_eval u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_time(sample_time),
    .done(done), .position(position), .velocity(velocity),
    .acceleration(acceleration), .phase(phase), .profile_ok(profile_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(position, velocity, acceleration, phase, profile_ok);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one register transfer on the configuration channel
  task write_cfg(bit [2:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, drain outstanding results, then let the pipeline empty
  task settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task load_profile(bit [31:0] pi, bit [31:0] pf, bit [31:0] vc, bit [31:0] dur,
                    bit [31:0] t0);
    settle();
    write_cfg(REG_INIT_POS, pi);
    write_cfg(REG_FINAL_POS, pf);
    write_cfg(REG_CRUISE_SPD, vc);
    write_cfg(REG_DURATION, dur);
    write_cfg(REG_START_TIME, t0);
    profiles++;
  endtask

  // one sample transfer; start stays high when no gap follows
  task send_sample(bit [31:0] ts);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    sample_time <= ts;
    do @(posedge clk); while (busy);
    sb.note_sample(ts);
    sent++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // feasible profile with random content; falls back to a fixed feasible profile
  task pick_feasible(output bit [31:0] pi, output bit [31:0] pf, output bit [31:0] vc,
                     output bit [31:0] dur);
    longint d, pfl;
    bit [63:0] ad, lo, hi, m;
    for (int k = 0; k < 200; k++) begin
      dur = $urandom() >> $urandom_range(0, 30);
      if (dur == 0) dur = 1;
      pi = $urandom();
      d = longint'($signed($urandom())) >>> $urandom_range(0, 31);
      pfl = longint'($signed(pi)) + d;
      if (pfl > 64'sd2147483647 || pfl < -64'sd2147483648 || d == 0) continue;
      pf = pfl[31:0];
      ad = d < 0 ? -d : d;
      lo = (ad << 16) / dur + 1;
      hi = (ad << 17) / {32'b0, dur};
      if (hi > 64'h7fff_ffff) hi = 64'h7fff_ffff;
      if (lo > hi) continue;
      m = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
      vc = d < 0 ? -m[31:0] : m[31:0];
      return;
    end
    pi = 0; pf = 32'h0001_0000; vc = 32'h0001_8000; dur = 32'h0001_0000;
  endtask

  // sample time mostly around the motion window
  function bit [31:0] near_window(bit [31:0] t0, bit [31:0] dur);
    longint off;
    if ($urandom_range(0, 9) == 0) return $urandom();
    off = longint'($urandom_range(0, 1000)) * longint'({32'b0, dur}) / 800
          - longint'({32'b0, dur}) / 8;
    if ($urandom_range(0, 7) == 0) off = longint'($urandom_range(0, 2)) * dur - 1
                                         + $urandom_range(0, 2);
    return t0 + off[31:0];
  endfunction

  initial begin
    bit [31:0] pi, pf, vc, dur, t0;
    int n;
    sb = new();
    cycles = 0; sent = 0; profiles = 0;
    rst = 1'b1;
    start = 1'b0;
    sample_time = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset profile has zero cruise speed and is infeasible
    send_sample(32'h0000_0000);
    send_sample(32'hffff_ffff);

    // full-range motion with the longest duration
    load_profile(32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000, 32'hffff_ffff, 32'h0);
    send_sample(32'h0);
    send_sample(32'h0000_0001);
    send_sample(32'h4000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'hc000_0000);
    send_sample(32'hffff_fffe);
    send_sample(32'hffff_ffff);

    // most negative cruise speed, descending, with late start
    load_profile(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0003_0000, 32'h0010_0000);
    send_sample(32'h000f_ffff);
    send_sample(32'h0010_0000);
    send_sample(32'h0011_0000);
    send_sample(32'h0011_8000);
    send_sample(32'h0012_ffff);
    send_sample(32'h0013_0000);
    send_sample(32'h0013_0001);

    // zero duration, opposite signs and too slow a speed are infeasible
    load_profile(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_sample(32'h0000_8000);
    settle();
    write_cfg(REG_DURATION, 32'h0001_0000);
    write_cfg(REG_CRUISE_SPD, 32'hffff_0000);
    send_sample(32'h0000_8000);
    settle();
    write_cfg(REG_CRUISE_SPD, 32'h0000_8000);
    send_sample(32'h0000_8000);
    // no motion at all
    settle();
    write_cfg(REG_FINAL_POS, 32'h0001_0000);
    write_cfg(3'd6, 32'hdead_beef);
    send_sample(32'h0000_8000);

    // random profiles, mostly feasible
    n = 0;
    while (n < RANDOM_SAMPLES) begin
      pick_feasible(pi, pf, vc, dur);
      t0 = ($urandom_range(0, 3) == 0) ? $urandom() : ($urandom() >> 4);
      case ($urandom_range(0, 9))
        0: vc = $urandom();
        1: dur = $urandom_range(0, 1) ? 32'h0 : $urandom();
        2: vc = -vc;
        default: ;
      endcase
      load_profile(pi, pf, vc, dur, t0);
      if ($urandom_range(0, 5) == 0) write_cfg(3'($urandom_range(5, 7)), $urandom());
      for (int i = 0; i < 65 && n < RANDOM_SAMPLES; i++) begin
        send_sample(near_window(t0, dur));
        n++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    settle();

    $display("%0d samples over %0d profiles, %0d feasible; phases %0d/%0d/%0d/%0d/%0d",
             sent, profiles, sb.feasible_seen, sb.phase_hits[0], sb.phase_hits[1],
             sb.phase_hits[2], sb.phase_hits[3], sb.phase_hits[4]);
    $display("%0d results compared, %0d mismatches", sb.matched, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tvp_pkg.sv
rtl/core/trapezoid_velocity_profile_eval.sv
dv/trapezoid_velocity_profile_eval_test.sv
